>>> rtl/core/urf_pkg.sv
// Package for the UART register file: item, result and state types,
// action and status codes, register offsets and bit constants.
// No dependencies.
`default_nettype none
package urf_pkg;

	typedef enum logic [1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_RECV  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_BUSY    = 2'd2
	} status_t;

	localparam logic [2:0] OFF_RBR = 3'd0;
	localparam logic [2:0] OFF_IER = 3'd1;
	localparam logic [2:0] OFF_IIR = 3'd2;
	localparam logic [2:0] OFF_LCR = 3'd3;
	localparam logic [2:0] OFF_MCR = 3'd4;
	localparam logic [2:0] OFF_LSR = 3'd5;
	localparam logic [2:0] OFF_MSR = 3'd6;
	localparam logic [2:0] OFF_SCR = 3'd7;

	localparam logic [3:0] SIZE_BYTE = 4'd1;
	localparam int         LCR_DLAB_BIT = 7;
	localparam int         IER_RX_BIT = 0;
	localparam int         IER_TX_BIT = 1;
	localparam logic [2:0] IIR_NONE = 3'h1;
	localparam logic [2:0] IIR_TX   = 3'h2;
	localparam logic [2:0] IIR_RX   = 3'h4;
	localparam logic [7:0] LSR_BASE = 8'h60;
	localparam logic [7:0] FCR_MASK = 8'hc9;

	typedef struct packed {
		logic [7:0] data_in;
		logic [3:0] access_size;
		logic [3:0] reg_offset;
		logic [1:0] action;
	} item_t;

	typedef struct packed {
		logic       irq_level;
		logic [7:0] tx_byte;
		logic       tx_valid;
		logic [1:0] status;
		logic [7:0] read_data;
	} result_t;

	typedef struct packed {
		logic [3:0]  int_enable;
		logic [2:0]  int_ident;
		logic [7:0]  fifo_control;
		logic [7:0]  line_control;
		logic [4:0]  modem_control;
		logic [7:0]  scratch;
		logic [7:0]  rx_holding;
		logic        data_ready;
		logic [15:0] baud_divisor;
		logic        irq_line;
	} state_t;

endpackage
`default_nettype wire

>>> rtl/core/uart_register_file_unit.sv
// Top level of the 16550-style UART register file: input register, decode,
// register state and output register. Depends on urf_pkg, urf_decode, urf_state.
//
// Each input transaction is one bus read, one bus write or one received byte,
// and yields exactly one result transaction. The block takes one item per
// clock when the output side keeps up; an item waits in the input register
// until the output register is free or its result is being taken, and the
// result is then offered from the output register until it is taken. The
// register update happens in the cycle the item moves from the input register
// into the output register, which keeps results in order with the register
// state. A new item is accepted while a result still waits, as long as the
// input register is free or moving on.
`default_nettype none
module uart_register_file_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,  // reg_offset[3:0], access_size[7:4], data_in[15:8]
	input  wire  [1:0]  s_tuser,  // action[1:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,  // read_data[7:0], tx_valid[8], tx_byte[16:9],
	                              // irq_level[17], zero[23:18]
	output logic [1:0]  m_tuser   // status[1:0]
);
	import urf_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t res_s2;
	logic    adv;
	state_t  state_cur;
	state_t  state_nxt;
	result_t res;

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.action      <= s_tuser;
			item_s1.reg_offset  <= s_tdata[3:0];
			item_s1.access_size <= s_tdata[7:4];
			item_s1.data_in     <= s_tdata[15:8];
		end
	end

	urf_decode u_decode (
		.item      (item_s1),
		.state_cur (state_cur),
		.state_nxt (state_nxt),
		.res       (res)
	);

	urf_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.state_nxt (state_nxt),
		.state_cur (state_cur)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, res_s2.irq_level, res_s2.tx_byte, res_s2.tx_valid,
		res_s2.read_data};
	assign m_tuser  = res_s2.status;

endmodule
`default_nettype wire

>>> rtl/core/urf_decode.sv
// Register decode for the UART register file: from one item and the current
// register state, forms the result and the next register state.
// Depends on urf_pkg.
`default_nettype none
module urf_decode (
	input  urf_pkg::item_t   item,
	input  urf_pkg::state_t  state_cur,
	output urf_pkg::state_t  state_nxt,
	output urf_pkg::result_t res
);
	import urf_pkg::*;

	logic       dlab;
	logic       refresh;
	logic       rx_int;
	logic       tx_int;
	logic [2:0] off;

	assign dlab = state_cur.line_control[LCR_DLAB_BIT];
	assign off  = item.reg_offset[2:0];

	always_comb begin
		state_nxt = state_cur;
		res       = '0;
		refresh   = 1'b0;
		rx_int    = 1'b0;
		tx_int    = 1'b0;
		case (action_t'(item.action))
			ACT_READ, ACT_WRITE: begin
				if (item.access_size != SIZE_BYTE || item.reg_offset[3]) begin
					res.status = ST_INVALID;
				end else if (action_t'(item.action) == ACT_READ) begin
					case (off)
						OFF_RBR: begin
							if (dlab) begin
								res.read_data = state_cur.baud_divisor[7:0];
							end else begin
								res.read_data        = state_cur.rx_holding;
								state_nxt.data_ready = 1'b0;
								refresh              = 1'b1;
							end
						end
						OFF_IER: begin
							res.read_data = dlab ? state_cur.baud_divisor[15:8]
								: {4'd0, state_cur.int_enable};
						end
						OFF_IIR: res.read_data = {5'd0, state_cur.int_ident};
						OFF_LCR: res.read_data = state_cur.line_control;
						OFF_MCR: res.read_data = {3'd0, state_cur.modem_control};
						OFF_LSR: res.read_data = LSR_BASE | {7'd0, state_cur.data_ready};
						OFF_MSR: res.read_data = 8'd0;
						default: res.read_data = state_cur.scratch;
					endcase
				end else begin
					case (off)
						OFF_RBR: begin
							if (dlab) begin
								state_nxt.baud_divisor[7:0] = item.data_in;
							end else begin
								res.tx_valid = 1'b1;
								res.tx_byte  = item.data_in;
							end
						end
						OFF_IER: begin
							if (dlab) begin
								state_nxt.baud_divisor[15:8] = item.data_in;
							end else begin
								state_nxt.int_enable = item.data_in[3:0];
								refresh              = 1'b1;
							end
						end
						OFF_IIR: state_nxt.fifo_control = item.data_in & FCR_MASK;
						OFF_LCR: state_nxt.line_control = item.data_in;
						OFF_MCR: state_nxt.modem_control = item.data_in[4:0];
						OFF_SCR: state_nxt.scratch = item.data_in;
						default: ;
					endcase
				end
			end
			ACT_RECV: begin
				if (state_cur.data_ready) begin
					res.status = ST_BUSY;
				end else begin
					state_nxt.rx_holding = item.data_in;
					state_nxt.data_ready = 1'b1;
					refresh              = 1'b1;
				end
			end
			default: res.status = ST_INVALID;
		endcase
		if (refresh) begin
			rx_int = state_nxt.int_enable[IER_RX_BIT] & state_nxt.data_ready;
			tx_int = state_nxt.int_enable[IER_TX_BIT];
			state_nxt.irq_line  = rx_int | tx_int;
			state_nxt.int_ident = rx_int ? IIR_RX : (tx_int ? IIR_TX : IIR_NONE);
		end
		res.irq_level = state_nxt.irq_line;
	end

endmodule
`default_nettype wire

>>> rtl/core/urf_state.sv
// Register state of the UART register file, with reset values; loads the
// next state when a transaction completes decode.
// Depends on urf_pkg.
`default_nettype none
module urf_state (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             load,
	input  urf_pkg::state_t state_nxt,
	output urf_pkg::state_t state_cur
);
	import urf_pkg::*;

	localparam state_t RESET_STATE = '{
		int_enable:    4'd0,
		int_ident:     IIR_NONE,
		fifo_control:  8'd0,
		line_control:  8'd0,
		modem_control: 5'd0,
		scratch:       8'd0,
		rx_holding:    8'd0,
		data_ready:    1'b0,
		baud_divisor:  16'd0,
		irq_line:      1'b0
	};

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RESET_STATE;
		end else if (load) begin
			state_q <= state_nxt;
		end
	end

	assign state_cur = state_q;

endmodule
`default_nettype wire
